// ----- rtl/dptq_pkg.sv -----
// ----------------------------------------------------------------------------
// dptq_pkg
// Shared types, widths and codes of the deadline priority task queue.
// ----------------------------------------------------------------------------
package dptq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 16;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int OP_W     = 2;
   localparam int LEVEL_W  = 3;
   localparam int TIME_W   = 40;
   localparam int EXP_W    = 41;
   localparam int TMO_W    = 30;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_LEVELS = 5;

   // Request operation codes; any code with the upper bit set drains.
   localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
   localparam logic [OP_W-1:0] OP_TAKE     = 2'd1;

   localparam logic [LEVEL_W-1:0] LEVEL_IDLE = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SLICE_OVER = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TMO_IMMEDIATE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TMO_USER_BLOCKING = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TMO_NORMAL        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TMO_LOW           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TMO_IDLE          = 3'd4;

   localparam logic [TMO_W-1:0] TMO_RESET_IMMEDIATE     = 30'd0;
   localparam logic [TMO_W-1:0] TMO_RESET_USER_BLOCKING = 30'd250;
   localparam logic [TMO_W-1:0] TMO_RESET_NORMAL        = 30'd5000;
   localparam logic [TMO_W-1:0] TMO_RESET_LOW           = 30'd10000;
   localparam logic [TMO_W-1:0] TMO_RESET_IDLE          = 30'd999999999;

   localparam logic [EXP_W-1:0] EXP_ALL_ONES = {EXP_W{1'b1}};

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [EXP_W-1:0]   expiration;
      logic [ID_BITS-1:0] id;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_cmd_type;

   // Strict ordering: lower level first, then earlier expiration.
   function automatic logic key_better(entry_type a, entry_type b);
      logic res;
      if (a.level != b.level) begin
         res = (a.level < b.level);
      end else begin
         res = (a.expiration < b.expiration);
      end
      return res;
   endfunction

endpackage

// ----- rtl/dptq_req_if.sv -----
// ----------------------------------------------------------------------------
// dptq_req_if
// Request channel of the task queue: valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface dptq_req_if;
   logic                           valid;
   logic                           ready;
   logic [dptq_pkg::OP_W-1:0]      op;
   logic [dptq_pkg::LEVEL_W-1:0]   level;
   logic [dptq_pkg::TIME_W-1:0]    now;
   logic [dptq_pkg::TIME_W-1:0]    slice_end;

   modport source (output valid, op, level, now, slice_end, input ready);
   modport sink   (input valid, op, level, now, slice_end, output ready);
endinterface

// ----- rtl/dptq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dptq_rsp_if
// Result channel of the task queue: valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface dptq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dptq_pkg::STATUS_W-1:0]     status;
   logic [dptq_pkg::ID_BITS-1:0]      task_id;
   logic [dptq_pkg::LEVEL_W-1:0]      task_level;
   logic [dptq_pkg::COUNT_BITS-1:0]   pending_count;
   logic [dptq_pkg::EXP_W-1:0]        next_deadline;
   logic                              yield_now;

   modport source (output valid, status, task_id, task_level, pending_count,
                   next_deadline, yield_now, input ready);
   modport sink   (input valid, status, task_id, task_level, pending_count,
                   next_deadline, yield_now, output ready);
endinterface

// ----- rtl/dptq_cell.sv -----
// ----------------------------------------------------------------------------
// dptq_cell
// One slot of the sorted chain: keep, take the new entry, or shift.
// ----------------------------------------------------------------------------
module dptq_cell (
   input  logic                   clock,
   input  dptq_pkg::cell_cmd_type cmd,
   input  logic                   occ,
   input  dptq_pkg::entry_type    new_entry,
   input  dptq_pkg::entry_type    prev_entry,
   input  logic                   prev_beat,
   input  dptq_pkg::entry_type    next_entry,
   output dptq_pkg::entry_type    entry,
   output logic                   beat
);
   import dptq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // New entry goes ahead of this slot when the slot is free or worse.
   assign beat  = !occ || key_better(new_entry, entry_ff);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.insert && beat) begin
         entry_in = prev_beat ? prev_entry : new_entry;
      end else if (cmd.pop) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/dptq_chain.sv -----
// ----------------------------------------------------------------------------
// dptq_chain
// Row of sorted cells; the best entry always sits in cell zero.
// ----------------------------------------------------------------------------
module dptq_chain (
   input  logic                              clock,
   input  dptq_pkg::cell_cmd_type            cmd,
   input  dptq_pkg::entry_type               new_entry,
   input  logic [dptq_pkg::COUNT_BITS-1:0]   count,
   output dptq_pkg::entry_type               head,
   output dptq_pkg::entry_type               second,
   output logic                              new_beats_head
);
   import dptq_pkg::*;

   entry_type entry_w [QUEUE_DEPTH];
   logic      beat_w  [QUEUE_DEPTH];
   logic      occ_w   [QUEUE_DEPTH];

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         entry_type prev_e;
         entry_type next_e;
         logic      prev_b;

         assign occ_w[g] = (count > COUNT_BITS'(g));

         if (g == 0) begin : g_first
            assign prev_e = entry_w[g];
            assign prev_b = 1'b0;
         end else begin : g_mid
            assign prev_e = entry_w[g-1];
            assign prev_b = beat_w[g-1];
         end

         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign next_e = entry_w[g];
         end else begin : g_inner
            assign next_e = entry_w[g+1];
         end

         dptq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occ        (occ_w[g]),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .prev_beat  (prev_b),
            .next_entry (next_e),
            .entry      (entry_w[g]),
            .beat       (beat_w[g])
         );
      end
   endgenerate

   assign head           = entry_w[0];
   assign second         = entry_w[1];
   assign new_beats_head = beat_w[0];

endmodule

// ----- rtl/deadline_priority_task_queue.sv -----
// ----------------------------------------------------------------------------
// deadline_priority_task_queue
// A request is captured on acceptance; execute then loads the output register and
// updates the sorted cell row. No new request is taken until execute is done.
// A result waiting on rsp stalls the execute cycle until the output register frees.
// Reset clears the entry count, the task id counter and loads default timeouts;
// queue slots are not cleared (only occupied slots are ever read).
// ----------------------------------------------------------------------------
module deadline_priority_task_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   dptq_req_if.sink                             req_bus,
   dptq_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [dptq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dptq_pkg::TMO_W-1:0]           csr_wdata
);
   import dptq_pkg::*;

   // Sequencer: idle (ready for a request) or executing one request.
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;

   // Timeout registers, one per level
   logic [TMO_W-1:0] timeout_ff [NUM_LEVELS];

   // Captured request
   logic [OP_W-1:0]    op_ff;
   logic [LEVEL_W-1:0] lvl_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [TIME_W-1:0]  slice_ff;
   logic [EXP_W-1:0]   exp_ff;

   // Queue bookkeeping
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ID_BITS-1:0]    id_ff, id_in;

   // Output register
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [LEVEL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic [EXP_W-1:0]      rsp_exp_ff, rsp_exp_in;
   logic                  rsp_yield_ff, rsp_yield_in;

   logic               req_fire;
   logic               exec_go;
   logic [LEVEL_W-1:0] lvl_clamped;
   logic [EXP_W-1:0]   exp_sum;

   cell_cmd_type cmd;
   entry_type    new_entry;
   entry_type    head;
   entry_type    second;
   logic         new_beats_head;
   logic         now_past_slice;
   logic         now_past_head;

   // ---------------------------------------------------------------------
   // Request capture: clamp the level and form the expiration time
   // ---------------------------------------------------------------------
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Levels above idle are treated as idle.
   assign lvl_clamped = (req_bus.level > LEVEL_IDLE) ? LEVEL_IDLE : req_bus.level;
   assign exp_sum     = {1'b0, req_bus.now} + {{(EXP_W-TMO_W){1'b0}}, timeout_ff[lvl_clamped]};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_bus.op;
         lvl_ff   <= lvl_clamped;
         now_ff   <= req_bus.now;
         slice_ff <= req_bus.slice_end;
         exp_ff   <= exp_sum;
      end
   end

   // ---------------------------------------------------------------------
   // Configuration writes; indexes past the last level are ignored
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff[CSR_TMO_IMMEDIATE]     <= TMO_RESET_IMMEDIATE;
         timeout_ff[CSR_TMO_USER_BLOCKING] <= TMO_RESET_USER_BLOCKING;
         timeout_ff[CSR_TMO_NORMAL]        <= TMO_RESET_NORMAL;
         timeout_ff[CSR_TMO_LOW]           <= TMO_RESET_LOW;
         timeout_ff[CSR_TMO_IDLE]          <= TMO_RESET_IDLE;
      end else if (csr_we && (csr_index <= CSR_TMO_IDLE)) begin
         timeout_ff[csr_index] <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------------
   // Execute: decide, command the cell row, and load the output register.
   // Only advance when the output register is free or being drained.
   // ---------------------------------------------------------------------
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   assign new_entry.level      = lvl_ff;
   assign new_entry.expiration = exp_ff;
   assign new_entry.id         = id_ff;

   assign now_past_slice = (now_ff >= slice_ff);
   assign now_past_head  = ({1'b0, now_ff} > head.expiration);

   always_comb begin
      cmd           = '0;
      count_in      = count_ff;
      id_in         = id_ff;
      rsp_status_in = ST_EMPTY;
      rsp_id_in     = '0;
      rsp_level_in  = '0;
      rsp_exp_in    = (count_ff == '0) ? EXP_ALL_ONES : head.expiration;

      priority if (op_ff == OP_SCHEDULE) begin
         if (count_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
            rsp_status_in = ST_FULL;
         end else begin
            cmd.insert    = exec_go;
            count_in      = count_ff + COUNT_BITS'(1);
            id_in         = id_ff + ID_BITS'(1);
            rsp_status_in = ST_ACCEPTED;
            rsp_id_in     = id_ff;
            rsp_level_in  = lvl_ff;
            // New head is the new entry when it sorts ahead of the old one.
            rsp_exp_in    = new_beats_head ? exp_ff : head.expiration;
         end
      end else if (count_ff == '0) begin
         rsp_status_in = ST_EMPTY;
      end else if ((op_ff == OP_TAKE) && now_past_slice) begin
         rsp_status_in = ST_SLICE_OVER;
      end else begin
         cmd.pop       = exec_go;
         count_in      = count_ff - COUNT_BITS'(1);
         rsp_id_in     = head.id;
         rsp_level_in  = head.level;
         rsp_status_in = ((op_ff == OP_TAKE) && now_past_head) ? ST_DROPPED : ST_DISPATCHED;
         rsp_exp_in    = (count_ff == COUNT_BITS'(1)) ? EXP_ALL_ONES : second.expiration;
      end

      rsp_yield_in = (count_in != '0) && ({1'b0, now_ff} >= rsp_exp_in);
   end

   dptq_chain u_chain (
      .clock          (clock),
      .cmd            (cmd),
      .new_entry      (new_entry),
      .count          (count_ff),
      .head           (head),
      .second         (second),
      .new_beats_head (new_beats_head)
   );

   // ---------------------------------------------------------------------
   // Sequencer and bookkeeping
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         id_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            count_ff     <= count_in;
            id_ff        <= id_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload; holds while the result waits
   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_count_ff  <= count_in;
         rsp_exp_ff    <= rsp_exp_in;
         rsp_yield_ff  <= rsp_yield_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.task_id       = rsp_id_ff;
   assign rsp_bus.task_level    = rsp_level_ff;
   assign rsp_bus.pending_count = rsp_count_ff;
   assign rsp_bus.next_deadline = rsp_exp_ff;
   assign rsp_bus.yield_now     = rsp_yield_ff;

endmodule

// ----- tb/deadline_priority_task_queue_tb.sv -----
// ----------------------------------------------------------------------------
// deadline_priority_task_queue_tb
// Self-checking bench for the deadline priority task queue. A directed table
// covers empty takes, out-of-range levels, a full queue, the work slice
// running out, expired drops, drains and tie ordering. A full queue of equal
// keys then checks that scheduling order decides. Random phases under
// several timeout settings follow, with both channels idling at random. Each
// result is compared field by field with a queue predictor.
// ----------------------------------------------------------------------------
module deadline_priority_task_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dptq_pkg::*;

   // Both codes with the upper op bit set drain the queue.
   localparam logic [OP_W-1:0] OP_DRAIN     = 2'd2;
   localparam logic [OP_W-1:0] OP_DRAIN_ALT = 2'd3;

   localparam logic [LEVEL_W-1:0] LVL_IMMEDIATE     = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_USER_BLOCKING = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_NORMAL        = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_LOW           = 3'd3;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [TMO_W-1:0]  TMO_MAX  = '1;

   localparam logic [TMO_W-1:0] DEFAULT_TIMEOUTS [NUM_LEVELS] = '{
      TMO_RESET_IMMEDIATE, TMO_RESET_USER_BLOCKING, TMO_RESET_NORMAL,
      TMO_RESET_LOW, TMO_RESET_IDLE};
   localparam logic [CSR_IDX_W-1:0] TIMEOUT_CSRS [NUM_LEVELS] = '{
      CSR_TMO_IMMEDIATE, CSR_TMO_USER_BLOCKING, CSR_TMO_NORMAL,
      CSR_TMO_LOW, CSR_TMO_IDLE};

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [ID_BITS-1:0]    task_id;
      logic [LEVEL_W-1:0]    task_level;
      logic [COUNT_BITS-1:0] pending_count;
      logic [EXP_W-1:0]      next_deadline;
      logic                  yield_now;
   } task_result_type;

   // One table row: a request, how many times to send it, and optionally
   // the result it must produce.
   typedef struct {
      logic [OP_W-1:0]    op;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  now;
      logic [TIME_W-1:0]  slice_end;
      int unsigned        copies;
      bit                 has_known;
      task_result_type    known_result;
   } stim_row_type;

   localparam task_result_type NO_RESULT = '0;
   localparam task_result_type EMPTY_RESULT = '{
      status: ST_EMPTY, task_id: '0, task_level: '0, pending_count: '0,
      next_deadline: EXP_ALL_ONES, yield_now: 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TMO_W-1:0]     csr_wdata = '0;

   dptq_req_if req_bus ();
   dptq_rsp_if rsp_bus ();

   // Side record that travels with each request: the typed-in result, if any.
   bit              row_known  = 1'b0;
   task_result_type row_result = '0;

   // Queue predictor state
   entry_type          queue_slots [QUEUE_DEPTH];
   int unsigned        slot_count;
   logic [ID_BITS-1:0] next_task_id;
   logic [TMO_W-1:0]   level_timeout [NUM_LEVELS];

   task_result_type awaited_results [$];
   int              fault_count = 0;

   bit               idling_on = 1'b0;
   int unsigned      rsp_hold_cycles = 0;
   logic [TMO_W-1:0] timeout_plan [NUM_LEVELS];
   stim_row_type     directed_rows [19];

   deadline_priority_task_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Index of the entry a take would pop: lowest level, then earliest
   // expiration; a strict compare keeps the earliest scheduled on a tie.
   function automatic int unsigned best_slot();
      int unsigned best = 0;
      for (int unsigned i = 1; i < slot_count; i++) begin
         if (queue_slots[i].level != queue_slots[best].level) begin
            if (queue_slots[i].level < queue_slots[best].level) best = i;
         end else if (queue_slots[i].expiration < queue_slots[best].expiration) begin
            best = i;
         end
      end
      return best;
   endfunction

   // Apply one request to the predicted queue and return its result.
   function automatic task_result_type advance_task_queue(logic [OP_W-1:0] op,
                                                          logic [LEVEL_W-1:0] level_in,
                                                          logic [TIME_W-1:0] now,
                                                          logic [TIME_W-1:0] slice_end);
      task_result_type    res;
      logic [LEVEL_W-1:0] lvl;
      entry_type          picked;
      int unsigned        idx;
      res = NO_RESULT;
      // Fold levels past idle onto idle.
      lvl = (level_in > LEVEL_IDLE) ? LEVEL_IDLE : level_in;
      if (op == OP_SCHEDULE) begin
         if (slot_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            queue_slots[slot_count].level      = lvl;
            queue_slots[slot_count].expiration = EXP_W'(now) + EXP_W'(level_timeout[lvl]);
            queue_slots[slot_count].id         = next_task_id;
            slot_count++;
            res.status     = ST_ACCEPTED;
            res.task_id    = next_task_id;
            res.task_level = lvl;
            next_task_id++;
         end
      end else if (slot_count == 0) begin
         res.status = ST_EMPTY;
      end else if (op == OP_TAKE && now >= slice_end) begin
         res.status = ST_SLICE_OVER;
      end else begin
         idx    = best_slot();
         picked = queue_slots[idx];
         for (int unsigned i = idx; i + 1 < slot_count; i++) begin
            queue_slots[i] = queue_slots[i + 1];
         end
         slot_count--;
         res.task_id    = picked.id;
         res.task_level = picked.level;
         res.status     = (op == OP_TAKE && EXP_W'(now) > picked.expiration) ?
                          ST_DROPPED : ST_DISPATCHED;
      end
      res.pending_count = COUNT_BITS'(slot_count);
      if (slot_count == 0) begin
         res.next_deadline = EXP_ALL_ONES;
         res.yield_now     = 1'b0;
      end else begin
         res.next_deadline = queue_slots[best_slot()].expiration;
         res.yield_now     = (EXP_W'(now) >= res.next_deadline);
      end
      return res;
   endfunction

   function automatic void check_field(string field_name, logic [63:0] want,
                                       logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field_name, want, got);
         fault_count++;
      end
   endfunction

   // Track register writes and accepted requests; queue one expectation per
   // request, the typed-in one where the table supplies it.
   always @(posedge clock) begin : queue_predictor
      task_result_type predicted;
      if (reset) begin
         slot_count    = 0;
         next_task_id  = '0;
         level_timeout = DEFAULT_TIMEOUTS;
      end else begin
         if (csr_we && csr_index < NUM_LEVELS) level_timeout[csr_index] = csr_wdata;
         if (req_bus.valid && req_bus.ready) begin
            predicted = advance_task_queue(req_bus.op, req_bus.level, req_bus.now,
                                           req_bus.slice_end);
            awaited_results.push_back(row_known ? row_result : predicted);
         end
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : result_checker
      task_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            $error("result with no request outstanding, status %0d", rsp_bus.status);
            fault_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("task_id", want.task_id, rsp_bus.task_id);
            check_field("task_level", want.task_level, rsp_bus.task_level);
            check_field("pending_count", want.pending_count, rsp_bus.pending_count);
            check_field("next_deadline", want.next_deadline, rsp_bus.next_deadline);
            check_field("yield_now", want.yield_now, rsp_bus.yield_now);
         end
      end
   end

   // Stall the result side: hold ready low for a random stretch now and then.
   always @(posedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_bus.ready   <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else if (idling_on && $urandom_range(0, 99) < 25) begin
         rsp_bus.ready   <= 1'b0;
         rsp_hold_cycles <= pick_gap() - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Present one request and hold it until the block takes it. Valid stays
   // high across back-to-back requests; it drops only for a gap.
   task automatic send_request(input stim_row_type row);
      if (idling_on && $urandom_range(0, 99) < 30) begin
         req_bus.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= row.op;
      req_bus.level     <= row.level;
      req_bus.now       <= row.now;
      req_bus.slice_end <= row.slice_end;
      row_known         <= row.has_known;
      row_result        <= row.known_result;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every result is back, then let the pipeline go quiet.
   task automatic settle_queue();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all five timeouts from timeout_plan, one register per cycle.
   task automatic load_timeouts();
      for (int r = 0; r < NUM_LEVELS; r++) begin
         csr_we    <= 1'b1;
         csr_index <= TIMEOUT_CSRS[r];
         csr_wdata <= timeout_plan[r];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      stim_row_type  row;
      int unsigned   leftover;
      int unsigned   roll;
      int unsigned   fill_bias;
      int unsigned   step_cap;
      logic [TIME_W-1:0] clock_ms;

      req_bus.valid     = 1'b0;
      req_bus.op        = OP_SCHEDULE;
      req_bus.level     = LVL_IMMEDIATE;
      req_bus.now       = '0;
      req_bus.slice_end = '0;
      rsp_bus.ready     = 1'b0;

      // Default timeouts: immediate 0, user blocking 250, normal 5000,
      // low 10000, idle 999999999.
      directed_rows = '{
         // Takes of every kind on the empty queue after reset
         '{OP_TAKE,      LVL_IMMEDIATE, '0, TIME_MAX, 1, 1'b1, EMPTY_RESULT},
         '{OP_DRAIN,     LVL_IMMEDIATE, '0, TIME_MAX, 1, 1'b1, EMPTY_RESULT},
         '{OP_DRAIN_ALT, LEVEL_IDLE,    TIME_MAX, '0, 1, 1'b1, EMPTY_RESULT},
         // First id, zero timeout: due at once, so yield is set
         '{OP_SCHEDULE, LVL_IMMEDIATE, '0, '0, 1, 1'b1,
           '{ST_ACCEPTED, '0, LVL_IMMEDIATE, 5'd1, '0, 1'b1}},
         // Largest time plus the idle timeout
         '{OP_SCHEDULE, LEVEL_IDLE, TIME_MAX, '0, 1, 1'b0, NO_RESULT},
         // Levels past idle are kept as idle
         '{OP_SCHEDULE, 3'd7, 40'd1000, '0, 1, 1'b0, NO_RESULT},
         '{OP_SCHEDULE, 3'd5, 40'd2000, '0, 1, 1'b0, NO_RESULT},
         '{OP_SCHEDULE, 3'd6, 40'd3000, '0, 1, 1'b0, NO_RESULT},
         '{OP_SCHEDULE, LVL_USER_BLOCKING, 40'd100, '0, 1, 1'b0, NO_RESULT},
         '{OP_SCHEDULE, LVL_NORMAL,        40'd100, '0, 1, 1'b0, NO_RESULT},
         '{OP_SCHEDULE, LVL_LOW,           40'd100, '0, 1, 1'b0, NO_RESULT},
         // Slice ends exactly now: nothing is popped
         '{OP_TAKE, LVL_IMMEDIATE, 40'd500, 40'd500, 1, 1'b0, NO_RESULT},
         // Fill to the brim with equal keys
         '{OP_SCHEDULE, LVL_NORMAL, 40'd200, '0, 8, 1'b0, NO_RESULT},
         // Full: nothing stored, the immediate entry is still best
         '{OP_SCHEDULE, LVL_IMMEDIATE, '0, '0, 1, 1'b1,
           '{ST_FULL, '0, '0, 5'd16, '0, 1'b1}},
         // Immediate entry has expired: dropped
         '{OP_TAKE, LVL_IMMEDIATE, 40'd1, TIME_MAX, 1, 1'b0, NO_RESULT},
         // User blocking entry still in time: dispatched
         '{OP_TAKE, LVL_IMMEDIATE, '0, 40'd1, 1, 1'b0, NO_RESULT},
         // Drains ignore a spent slice and expiry
         '{OP_DRAIN,     LVL_IMMEDIATE, TIME_MAX, '0, 1, 1'b0, NO_RESULT},
         '{OP_DRAIN_ALT, LVL_IMMEDIATE, TIME_MAX, '0, 1, 1'b0, NO_RESULT},
         // Tied normal entries leave oldest first, here as expired drops
         '{OP_TAKE, LVL_IMMEDIATE, 40'd6000, TIME_MAX, 1, 1'b0, NO_RESULT}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      idling_on = 1'b1;
      foreach (directed_rows[i]) begin
         for (int k = 0; k < directed_rows[i].copies; k++) send_request(directed_rows[i]);
      end
      settle_queue();

      // Empty the queue without gaps.
      idling_on = 1'b0;
      leftover = slot_count;
      row = '{OP_DRAIN, LVL_IMMEDIATE, '0, '0, 1, 1'b0, NO_RESULT};
      repeat (leftover) send_request(row);
      settle_queue();

      // Equal keys in a full queue: scheduling order decides.
      idling_on = 1'b1;
      row = '{OP_SCHEDULE, LVL_LOW, 40'd5000, TIME_MAX, 1, 1'b0, NO_RESULT};
      repeat (QUEUE_DEPTH) send_request(row);
      row.op = OP_TAKE;
      repeat (QUEUE_DEPTH) send_request(row);
      settle_queue();

      // Random phases, one timeout setting each.
      for (int phase = 0; phase < 6; phase++) begin
         for (int r = 0; r < NUM_LEVELS; r++) begin
            case (phase)
               0: timeout_plan[r] = '0;
               1: timeout_plan[r] = TMO_MAX;
               2: timeout_plan[r] = TMO_W'($urandom_range(0, 300));
               3: timeout_plan[r] = TMO_W'($urandom_range(0, TMO_MAX));
               4: begin
                  roll = $urandom_range(0, 2);
                  timeout_plan[r] = (roll == 0) ? '0 : (roll == 1) ? TMO_MAX :
                                    TMO_W'($urandom_range(0, 500));
               end
               default: timeout_plan[r] = DEFAULT_TIMEOUTS[r];
            endcase
         end
         load_timeouts();
         clock_ms = (phase % 2 == 0) ? TIME_W'($urandom_range(0, 1000)) :
                                       TIME_W'({$urandom, $urandom});

         for (int n = 0; n < 105; n++) begin
            // Quiet stretches with no idling on either side.
            idling_on = ((n / 30) % 3) != 2;
            // Alternate fill and drain bursts so both full and empty come up.
            fill_bias = ((n / 20) % 2 == 0) ? 75 : 25;

            row.copies       = 1;
            row.has_known    = 1'b0;
            row.known_result = NO_RESULT;
            roll = $urandom_range(0, 99);
            row.level = (roll < 10) ? LEVEL_W'($urandom_range(5, 7)) :
                                      LEVEL_W'($urandom_range(0, 4));
            if ($urandom_range(0, 99) < fill_bias) begin
               row.op = OP_SCHEDULE;
            end else begin
               roll = $urandom_range(0, 99);
               row.op = (roll < 60) ? OP_TAKE : (roll < 85) ? OP_DRAIN : OP_DRAIN_ALT;
            end

            // Advance time in steps scaled to the timeout in play.
            step_cap = timeout_plan[(row.level > LEVEL_IDLE) ? LEVEL_IDLE : row.level] / 3 + 3;
            clock_ms = clock_ms + TIME_W'($urandom_range(0, step_cap));
            roll = $urandom_range(0, 99);
            if (roll < 4)      row.now = TIME_W'({$urandom, $urandom});
            else if (roll < 6) row.now = '0;
            else if (roll < 8) row.now = TIME_MAX;
            else               row.now = clock_ms;

            // Mostly a slice still open; sometimes spent, sometimes anywhere.
            roll = $urandom_range(0, 99);
            if (roll < 70)
               row.slice_end = row.now + 1 + TIME_W'($urandom_range(0, 4 * step_cap));
            else if (roll < 85)
               row.slice_end = row.now - TIME_W'($urandom_range(0, step_cap));
            else if (roll < 95)
               row.slice_end = TIME_W'({$urandom, $urandom});
            else
               row.slice_end = row.now;

            send_request(row);
         end
         settle_queue();
      end

      if (fault_count == 0 && awaited_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
